// File: sv/next_fit_id_allocator_top_assert.svh
// Assertion macros for the id allocator.
`ifndef NEXT_FIT_ID_ALLOCATOR_TOP_ASSERT_SVH
`define NEXT_FIT_ID_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define NFIA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("id allocator check failed");
`define NFIA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id allocator sequence check failed");
`else
`define NFIA_ASSERT(lbl, cond)
`define NFIA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: sv/nfia_pkg.sv
`default_nettype none
package nfia_pkg;

    localparam int NUM_IDS  = 64;
    localparam int SLOT_W   = $clog2(NUM_IDS);
    localparam int ID_W     = 7;
    localparam int STATUS_W = 2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_FREE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] slot;
    } map_cmd_t;

endpackage
`default_nettype wire

// File: sv/nfia_if.sv
`default_nettype none
interface nfia_req_if;
    import nfia_pkg::*;
    logic            valid;
    logic            ready;
    logic            func;
    logic [ID_W-1:0] free_id;

    modport source (output valid, func, free_id, input ready);
    modport sink   (input valid, func, free_id, output ready);
endinterface

interface nfia_rsp_if;
    import nfia_pkg::*;
    logic                valid;
    logic                ready;
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;

    modport source (output valid, granted_id, status, input ready);
    modport sink   (input valid, granted_id, status, output ready);
endinterface
`default_nettype wire

// File: sv/next_fit_id_allocator_top.sv
// Next-fit id allocator.
// Free: checked and cleared in the accept cycle; the result goes to the res registers,
// then through S_HOLD into the output register. Allocate: accept, then scan up to NUM_IDS
// slots, one slot probed per cycle through the single bitmap read port; then via S_HOLD out.
// One transaction in flight; a new request is taken only once the last result is in the output register.
// rst_n is asynchronous, active low: bitmap cleared, pointer to slot 0.
`default_nettype none
module next_fit_id_allocator_top (
    input wire logic   clk,
    input wire logic   rst_n,
    nfia_req_if.sink   req,
    nfia_rsp_if.source rsp
);
    import nfia_pkg::*;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   last_slot_reg, last_slot_next;
    logic [SLOT_W-1:0]   scan_slot_reg, scan_slot_next;
    logic [SLOT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    status_t             res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_id_reg, out_id_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [SLOT_W-1:0] rd_slot;
    logic              rd_used;
    map_cmd_t          cmd;
    logic [SLOT_W-1:0] free_slot;
    logic              free_in_range;
    logic              accept;
    logic              load;
    logic              scan_hit;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(NUM_IDS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign free_slot     = SLOT_W'(req.free_id - ID_W'(1));
    assign free_in_range = (req.free_id != '0) && (req.free_id <= ID_W'(NUM_IDS));
    assign rd_slot       = (state_reg == S_IDLE) ? free_slot : scan_slot_reg;
    assign scan_hit      = (state_reg == S_SCAN) && !rd_used;
    assign load          = (state_reg == S_HOLD) && (!out_valid_reg || rsp.ready);

    nfia_slot_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (rd_slot),
        .rd_used (rd_used),
        .cmd     (cmd)
    );

    always_comb
    begin
        state_next      = state_reg;
        last_slot_next  = last_slot_reg;
        scan_slot_next  = scan_slot_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_id_next     = res_id_reg;
        res_status_next = res_status_reg;
        cmd             = '{set: 1'b0, clr: 1'b0, slot: rd_slot};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.func == FUNC_ALLOC)
                    begin
                        scan_slot_next = slot_inc(last_slot_reg);
                        scan_cnt_next  = '0;
                        state_next     = S_SCAN;
                    end
                    else
                    begin
                        res_id_next = '0;
                        if (free_in_range && rd_used)
                        begin
                            cmd.clr         = 1'b1;
                            res_status_next = ST_OK;
                        end
                        else
                        begin
                            res_status_next = ST_BAD_FREE;
                        end
                        state_next = S_HOLD;
                    end
                end
            end
            S_SCAN:
            begin
                if (!rd_used)
                begin
                    cmd.set         = 1'b1;
                    last_slot_next  = scan_slot_reg;
                    res_id_next     = ID_W'(scan_slot_reg) + ID_W'(1);
                    res_status_next = ST_OK;
                    state_next      = S_HOLD;
                end
                else if (scan_cnt_reg == SLOT_W'(NUM_IDS - 1))
                begin
                    res_id_next     = '0;
                    res_status_next = ST_EXHAUSTED;
                    state_next      = S_HOLD;
                end
                else
                begin
                    scan_slot_next = slot_inc(scan_slot_reg);
                    scan_cnt_next  = scan_cnt_reg + SLOT_W'(1);
                end
            end
            S_HOLD:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_status_next = out_status_reg;
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_id_next     = res_id_reg;
            out_status_next = res_status_reg;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_slot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_slot_reg <= last_slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_slot_reg  <= scan_slot_next;
        scan_cnt_reg   <= scan_cnt_next;
        res_id_reg     <= res_id_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.status     = out_status_reg;

`include "next_fit_id_allocator_top_assert.svh"

    `NFIA_ASSERT(a_grant_form, rsp.valid |-> (rsp.granted_id <= ID_W'(NUM_IDS)) && ((rsp.granted_id == '0) || (rsp.status == ST_OK)))
    `NFIA_ASSERT(a_last_range, last_slot_reg <= SLOT_W'(NUM_IDS - 1))
    `NFIA_ASSERT_NEXT(a_ptr_moves, scan_hit, (last_slot_reg == $past(scan_slot_reg)) && (state_reg == S_HOLD))
    `NFIA_ASSERT_NEXT(a_hold_out, load, rsp.valid && (rsp.granted_id == $past(res_id_reg)))

endmodule
`default_nettype wire

// File: sv/nfia_slot_map.sv
`default_nettype none
module nfia_slot_map (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [nfia_pkg::SLOT_W-1:0] rd_slot,
    output logic                             rd_used,
    input  wire nfia_pkg::map_cmd_t          cmd
);
    import nfia_pkg::*;

    logic [NUM_IDS-1:0] map_reg;
    logic [NUM_IDS-1:0] map_next;

    assign rd_used = map_reg[rd_slot];

    always_comb
    begin
        map_next = map_reg;
        if (cmd.set)
        begin
            map_next[cmd.slot] = 1'b1;
        end
        else if (cmd.clr)
        begin
            map_next[cmd.slot] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

endmodule
`default_nettype wire

// File: sim/next_fit_id_allocator_checker.sv
module next_fit_id_allocator_checker (
    input  logic clk,
    input  logic rst_n,
    nfia_req_if  req,
    nfia_rsp_if  rsp,
    output int   errors,
    output int   outstanding,
    output int   grants,
    output int   exhausts,
    output int   frees,
    output int   rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    import nfia_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0] granted_id;
        status_t         status;
    } grant_t;

    logic [NUM_IDS-1:0] busy_map = '0;
    logic [SLOT_W-1:0]  ptr_slot = '0;
    grant_t             grant_q[$];

    initial
    begin
        errors   = 0;
        grants   = 0;
        exhausts = 0;
        frees    = 0;
        rejects  = 0;
        outstanding = 0;
    end

    task automatic report(input string what);
        $display("[%0t] ERROR %s", $time, what);
        errors++;
    endtask

    // next-fit search from the slot after the last grant, wrapping
    function automatic grant_t next_fit(input logic func, input logic [ID_W-1:0] id);
        grant_t g;
        int     slot;
        g.granted_id = '0;
        g.status     = ST_OK;
        if (func == FUNC_ALLOC)
        begin
            g.status = ST_EXHAUSTED;
            slot     = int'(ptr_slot);
            for (int n = 0; n < NUM_IDS; n++)
            begin
                slot = (slot + 1) % NUM_IDS;
                if (!busy_map[SLOT_W'(slot)])
                begin
                    busy_map[SLOT_W'(slot)] = 1'b1;
                    ptr_slot       = SLOT_W'(slot);
                    g.granted_id   = ID_W'(slot + 1);
                    g.status       = ST_OK;
                    break;
                end
            end
            if (g.status == ST_OK)
                grants++;
            else
                exhausts++;
        end
        else if (id == 0 || id > NUM_IDS || !busy_map[SLOT_W'(id - ID_W'(1))])
        begin
            g.status = ST_BAD_FREE;
            rejects++;
        end
        else
        begin
            busy_map[SLOT_W'(id - ID_W'(1))] = 1'b0;
            frees++;
        end
        return g;
    endfunction

    task automatic check_grant();
        grant_t want;
        if (grant_q.size() == 0)
        begin
            report($sformatf("unexpected result: id %0d status %0d",
                             rsp.granted_id, rsp.status));
            return;
        end
        want = grant_q.pop_front();
        if (rsp.granted_id !== want.granted_id)
            report($sformatf("granted_id %0d, expected %0d",
                             rsp.granted_id, want.granted_id));
        if (rsp.status !== want.status)
            report($sformatf("status %0d, expected %0d (%s)",
                             rsp.status, want.status, want.status.name()));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_map = '0;
            ptr_slot = '0;
            grant_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
                check_grant();
            if (req.valid && req.ready)
                grant_q = {grant_q, next_fit(req.func, req.free_id)};
            outstanding <= grant_q.size();
        end
    end

endmodule

// File: sim/next_fit_id_allocator_top_tb.sv
module next_fit_id_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nfia_pkg::*;

    localparam int IDLE_MAX    = 18;
    localparam int TOTAL_ITEMS = 700;
    localparam int LONG_AT     = 100;
    localparam int LONG_HOLD   = 400;
    localparam int WATCHDOG    = 4000;
    localparam int DRAIN       = 2 * NUM_IDS + 8;
    localparam int ID_TOP      = (1 << ID_W) - 1;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int outstanding;
    int grants;
    int exhausts;
    int frees;
    int rejects;

    int unsigned req_idle = 0;
    int unsigned rsp_idle = 0;
    int          sent     = 0;
    int          quiet    = 0;

    nfia_req_if req_ch();
    nfia_rsp_if rsp_ch();

    next_fit_id_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    next_fit_id_allocator_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .errors      (errors),
        .outstanding (outstanding),
        .grants      (grants),
        .exhausts    (exhausts),
        .frees       (frees),
        .rejects     (rejects)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned draw_wait(input int unsigned max_wait);
        return (max_wait == 0) ? 0 : $urandom_range(max_wait, 0);
    endfunction

    // mostly in-range ids, some zero or above range
    function automatic logic [ID_W-1:0] pick_free_id();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return ID_W'($urandom_range(ID_TOP, NUM_IDS + 1));
            default: return ID_W'($urandom_range(NUM_IDS, 1));
        endcase
    endfunction

    task automatic offer(input logic func, input logic [ID_W-1:0] id);
        int unsigned gap;
        gap = draw_wait(req_idle);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.func    <= func;
        req_ch.free_id <= id;
        do @(posedge clk); while (!req_ch.ready);
        sent++;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin : result_sink
        int unsigned gap;
        int          taken;
        taken = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = (taken == LONG_AT) ? LONG_HOLD : draw_wait(rsp_idle);
            if (gap != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == WATCHDOG)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int span;
        int alloc_pct;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= FUNC_ALLOC;
        req_ch.free_id <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rejected frees on an empty map
        offer(FUNC_FREE, ID_W'(0));
        offer(FUNC_FREE, ID_W'(NUM_IDS));
        offer(FUNC_FREE, ID_W'(NUM_IDS + 1));
        offer(FUNC_FREE, ID_W'(ID_TOP));
        // first search starts past slot 0
        repeat (4) offer(FUNC_ALLOC, '0);
        offer(FUNC_FREE, ID_W'(3));
        offer(FUNC_FREE, ID_W'(3));
        // next fit skips the hole just freed; free_id ignored
        offer(FUNC_ALLOC, '1);
        offer(FUNC_FREE, ID_W'(2));
        offer(FUNC_FREE, ID_W'(4));
        offer(FUNC_FREE, ID_W'(5));
        offer(FUNC_FREE, ID_W'(6));
        settle();

        // fill to exhaustion, drain, mix
        phase = 0;
        while (sent < TOTAL_ITEMS)
        begin
            req_idle  = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
            rsp_idle  = ($urandom_range(3, 0) == 0) ? 0 : IDLE_MAX;
            alloc_pct = (phase % 3 == 0) ? 90 : (phase % 3 == 1) ? 15 : 50;
            span      = $urandom_range(110, 70);
            if (span > TOTAL_ITEMS - sent)
                span = TOTAL_ITEMS - sent;
            repeat (span)
            begin
                if ($urandom_range(99, 0) < alloc_pct)
                    offer(FUNC_ALLOC, ID_W'($urandom));
                else
                    offer(FUNC_FREE, pick_free_id());
            end
            if (phase % 2 == 1)
                settle();
            phase++;
        end
        settle();
        repeat (DRAIN) @(posedge clk);

        $display("run covered %0d requests: %0d grants, %0d exhausted allocations,",
                 sent, grants, exhausts);
        $display("%0d frees, %0d rejected frees, one %0d-cycle result stall",
                 frees, rejects, LONG_HOLD);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/nfia_pkg.sv
sv/nfia_if.sv
sv/nfia_slot_map.sv
sv/next_fit_id_allocator_top.sv
sim/next_fit_id_allocator_checker.sv
sim/next_fit_id_allocator_top_tb.sv
